/* sv/rbd_pkg.sv */
`default_nettype none

package rbd_pkg;

  // Fixed field widths at the block's ports
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned ITEM_PORT_W = 64;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 7;

  // Default sizing of the ring store
  localparam int unsigned RBD_DEPTH      = 64;
  localparam int unsigned RBD_ITEM_WIDTH = 64;

  // Request opcodes; codes 5 to 7 are no-ops
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_HEAD = 3'd0,
    CMD_PUSH_TAIL = 3'd1,
    CMD_POP_HEAD  = 3'd2,
    CMD_POP_TAIL  = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // perform the latched request
  } dp_ctl_t;

endpackage

`default_nettype wire

/* sv/ring_buffer_deque.sv */
// Double-ended queue in a fixed ring store of DEPTH slots.
// Request channel: cmd_i, item_in_i, position_i; a request is taken at a
// rising edge with start_i high and busy_o low.
// Result channel: item_out_o, status_o, count_o, valid for the single
// cycle in which done_o is high; the receiver cannot stall it.
// Opcodes: push head, push tail, pop head, pop tail, read at index.
// Status: ok, full (push refused), empty (pop refused), out of range.
// count_o is the number of items held after the request.
// busy_o is high in S_EXEC, the state after the accepting edge, and
// done_o is high in S_DONE, which follows S_EXEC; the result is taken
// while done_o is high. A new request can be taken in the cycle done_o
// is high, but not while busy_o is high; the pace is set by the store's
// registered read port plus the result state.
// Reset clears head pointer and fill count; store contents stay as they
// are and are only read at live positions, so no clearing pass.
`default_nettype none

module ring_buffer_deque import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = RBD_DEPTH,
  parameter int unsigned ITEM_WIDTH = RBD_ITEM_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [CMD_W-1:0]       cmd_i,
  input  wire logic [ITEM_PORT_W-1:0] item_in_i,
  input  wire logic [POS_W-1:0]       position_i,
  output logic                        done_o,
  output logic [ITEM_PORT_W-1:0]      item_out_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [COUNT_W-1:0]          count_o
);

  dp_ctl_t ctl;

  rbd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .ctl_o   (ctl)
  );

  rbd_datapath #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cmd_i      (cmd_i),
    .item_in_i  (item_in_i),
    .position_i (position_i),
    .item_out_o (item_out_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

endmodule

`default_nettype wire

/* sv/rbd_datapath.sv */
`default_nettype none

module rbd_datapath import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = RBD_DEPTH,
  parameter int unsigned ITEM_WIDTH = RBD_ITEM_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dp_ctl_t                ctl_i,
  input  wire logic [CMD_W-1:0]       cmd_i,
  input  wire logic [ITEM_PORT_W-1:0] item_in_i,
  input  wire logic [POS_W-1:0]       position_i,
  output logic [ITEM_PORT_W-1:0]      item_out_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [COUNT_W-1:0]          count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned SW = ((FW > POS_W) ? FW : POS_W) + 1;

  // Latched request
  cmd_e                  cmd_q;
  logic [ITEM_WIDTH-1:0] item_q;
  logic [POS_W-1:0]      pos_q;

  // Queue state and result
  logic [AW-1:0]         head_q, head_d;
  logic [FW-1:0]         fill_q, fill_d;
  status_e               status_q, status_d;
  logic                  give_q, give_d;
  logic [ITEM_WIDTH-1:0] rd_q;

  // Ring store
  logic [ITEM_WIDTH-1:0] mem [DEPTH];

  logic [SW-1:0] lidx;
  logic [SW-1:0] sum;
  logic [SW-1:0] slot;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] addr;
  logic          full;
  logic          empty;
  logic          out_of_range;
  logic          we;
  logic          re;

  // Logical index to slot: head plus index, wrapped once
  assign sum  = SW'(head_q) + lidx;
  assign slot = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;

  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : (head_q - AW'(1));
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : (head_q + AW'(1));

  assign full         = (fill_q == FW'(DEPTH));
  assign empty        = (fill_q == '0);
  assign out_of_range = (SW'(pos_q) >= SW'(fill_q));

  // Decode the latched request
  always_comb begin
    lidx     = SW'(fill_q);
    status_d = ST_OK;
    head_d   = head_q;
    fill_d   = fill_q;
    give_d   = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    addr     = slot[AW-1:0];
    unique case (cmd_q)
      CMD_PUSH_HEAD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          head_d = head_dec;
          addr   = head_dec;
          we     = 1'b1;
          fill_d = fill_q + FW'(1);
        end
      end
      CMD_PUSH_TAIL: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          fill_d = fill_q + FW'(1);
        end
      end
      CMD_POP_HEAD: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          addr   = head_q;
          re     = 1'b1;
          give_d = 1'b1;
          head_d = head_inc;
          fill_d = fill_q - FW'(1);
        end
      end
      CMD_POP_TAIL: begin
        // tail item sits at logical index fill - 1
        lidx = SW'(fill_q) - SW'(1);
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re     = 1'b1;
          give_d = 1'b1;
          fill_d = fill_q - FW'(1);
        end
      end
      CMD_READ: begin
        lidx = SW'(pos_q);
        if (out_of_range) begin
          status_d = ST_RANGE;
        end else begin
          re     = 1'b1;
          give_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= cmd_e'(cmd_i);
      item_q <= item_in_i[ITEM_WIDTH-1:0];
      pos_q  <= position_i;
    end
  end

  // Pointer, fill and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      fill_q   <= '0;
      status_q <= ST_OK;
      give_q   <= 1'b0;
    end else if (ctl_i.execute) begin
      head_q   <= head_d;
      fill_q   <= fill_d;
      status_q <= status_d;
      give_q   <= give_d;
    end
  end

  // Store: one write or one registered read per request
  always_ff @(posedge clk_i) begin
    if (ctl_i.execute && we) begin
      mem[addr] <= item_q;
    end
    if (ctl_i.execute && re) begin
      rd_q <= mem[addr];
    end
  end

  // Result fields
  assign item_out_o = give_q ? ITEM_PORT_W'(rd_q) : '0;
  assign status_o   = status_q;
  assign count_o    = COUNT_W'(fill_q);

endmodule

`default_nettype wire

/* sv/rbd_ctrl.sv */
`default_nettype none

module rbd_ctrl import rbd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  output logic      done_o,
  output dp_ctl_t   ctl_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        // a new request may be taken while the result is shown
        state_d = start_i ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q == S_EXEC);
  assign done_o        = (state_q == S_DONE);
  assign ctl_o.capture = start_i && !busy_o;
  assign ctl_o.execute = (state_q == S_EXEC);

endmodule

`default_nettype wire

/* sv/rbd_checker.sv */
`default_nettype none

module rbd_checker import rbd_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start_i,
  input wire logic                   busy_o,
  input wire logic                   done_o,
  input wire logic [ITEM_PORT_W-1:0] item_out_o,
  input wire logic [STATUS_W-1:0]    status_o,
  input wire logic [COUNT_W-1:0]     count_o
);

  // An accepted request keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("request accepted but block not busy");

  // Every busy cycle is followed by a result, with busy low again
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (done_o && !busy_o))
    else $error("no result after busy cycle");

  // A result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // Refused requests return a zero item
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (item_out_o == '0))
    else $error("nonzero item on refused request");

  // Full can only be reported when the queue holds items
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (count_o != '0 || COUNT_W < 7))
    else $error("full reported with empty queue");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .item_out_o (item_out_o),
  .status_o   (status_o),
  .count_o    (count_o)
);

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import rbd_pkg::*;

  // Opcodes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int DIR_ROWS     = 23;
  localparam int PHASE_ITEMS  = 500;
  localparam int REPORT_LIMIT = 50;

  typedef struct {
    logic [ITEM_PORT_W-1:0] item;
    status_e                st;
    logic [COUNT_W-1:0]     cnt;
  } deque_result_t;

  typedef struct {
    logic [CMD_W-1:0]       op;
    logic [ITEM_PORT_W-1:0] data;
    logic [POS_W-1:0]       pos;
    bit                     typed;  // res below is the expected result
    deque_result_t          res;
  } dir_row_t;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   start_i    = 1'b0;
  logic [CMD_W-1:0]       cmd_i      = '0;
  logic [ITEM_PORT_W-1:0] item_in_i  = '0;
  logic [POS_W-1:0]       position_i = '0;
  logic                   busy_o;
  logic                   done_o;
  logic [ITEM_PORT_W-1:0] item_out_o;
  logic [STATUS_W-1:0]    status_o;
  logic [COUNT_W-1:0]     count_o;

  // Shadow copy of the deque
  logic [ITEM_PORT_W-1:0] slot_mem [RBD_DEPTH];
  logic [POS_W-1:0]       front = '0;
  logic [COUNT_W-1:0]     held  = '0;

  deque_result_t due_results [$];
  int            mismatch_cnt = 0;
  int            idle_pct     = 0;

  // Directed requests; typed rows carry their expected result
  dir_row_t dir_table [DIR_ROWS] = '{
    '{CMD_POP_HEAD,  64'h0,                  6'd0,  1'b1, '{64'h0, ST_EMPTY, 7'd0}},
    '{CMD_POP_TAIL,  64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, '{64'h0, ST_EMPTY, 7'd0}},
    '{CMD_READ,      64'h0,                  6'd0,  1'b1, '{64'h0, ST_RANGE, 7'd0}},
    '{CMD_READ,      64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, '{64'h0, ST_RANGE, 7'd0}},
    '{CMD_SPARE_5,   64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, '{64'h0, ST_OK,    7'd0}},
    '{CMD_SPARE_7,   64'h0,                  6'd0,  1'b1, '{64'h0, ST_OK,    7'd0}},
    '{CMD_PUSH_HEAD, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  1'b1, '{64'h0, ST_OK,    7'd1}},
    '{CMD_PUSH_TAIL, 64'h0,                  6'd63, 1'b1, '{64'h0, ST_OK,    7'd2}},
    '{CMD_PUSH_HEAD, 64'h8000_0000_0000_0001, 6'd0,  1'b1, '{64'h0, ST_OK,    7'd3}},
    '{CMD_PUSH_TAIL, 64'h5555_5555_5555_5555, 6'd0,  1'b1, '{64'h0, ST_OK,    7'd4}},
    '{CMD_READ,      64'h0,                  6'd0,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_READ,      64'h0,                  6'd3,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_READ,      64'h0,                  6'd4,  1'b1, '{64'h0, ST_RANGE, 7'd4}},
    '{CMD_READ,      64'h0,                  6'd63, 1'b1, '{64'h0, ST_RANGE, 7'd4}},
    '{CMD_SPARE_6,   64'hAAAA_AAAA_AAAA_AAAA, 6'd21, 1'b1, '{64'h0, ST_OK,    7'd4}},
    '{CMD_POP_TAIL,  64'h0,                  6'd0,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_POP_HEAD,  64'h0,                  6'd0,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_READ,      64'h0,                  6'd1,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_PUSH_TAIL, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_POP_HEAD,  64'h0,                  6'd0,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_POP_HEAD,  64'h0,                  6'd0,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_POP_TAIL,  64'h0,                  6'd0,  1'b0, '{64'h0, ST_OK,    7'd0}},
    '{CMD_POP_TAIL,  64'h0,                  6'd0,  1'b1, '{64'h0, ST_EMPTY, 7'd0}}
  };

  ring_buffer_deque dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .item_in_i  (item_in_i),
    .position_i (position_i),
    .done_o     (done_o),
    .item_out_o (item_out_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Picks one of the no-op opcodes
  function automatic logic [CMD_W-1:0] CMD_CMD_SPARE();
    case ($urandom_range(2))
      0:       return CMD_SPARE_5;
      1:       return CMD_SPARE_6;
      default: return CMD_SPARE_7;
    endcase
  endfunction

  // Apply one request to the shadow deque and work out its result
  task automatic apply_request(input logic [CMD_W-1:0] op, input logic [ITEM_PORT_W-1:0] data,
                               input logic [POS_W-1:0] pos, output deque_result_t res);
    logic [POS_W-1:0] idx;
    res.item = '0;
    res.st   = ST_OK;
    case (op)
      CMD_PUSH_HEAD: begin
        if (held == RBD_DEPTH) begin
          res.st = ST_FULL;
        end else begin
          front = front - 1'b1;
          slot_mem[front] = data;
          held = held + 1'b1;
        end
      end
      CMD_PUSH_TAIL: begin
        if (held == RBD_DEPTH) begin
          res.st = ST_FULL;
        end else begin
          idx = front + held[POS_W-1:0];
          slot_mem[idx] = data;
          held = held + 1'b1;
        end
      end
      CMD_POP_HEAD: begin
        if (held == 0) begin
          res.st = ST_EMPTY;
        end else begin
          res.item = slot_mem[front];
          front = front + 1'b1;
          held = held - 1'b1;
        end
      end
      CMD_POP_TAIL: begin
        if (held == 0) begin
          res.st = ST_EMPTY;
        end else begin
          // last live item, wrapping around the ring
          idx = front + held[POS_W-1:0] - 1'b1;
          res.item = slot_mem[idx];
          held = held - 1'b1;
        end
      end
      CMD_READ: begin
        if ({1'b0, pos} >= held) begin
          res.st = ST_RANGE;
        end else begin
          idx = front + pos;
          res.item = slot_mem[idx];
        end
      end
      default: ;
    endcase
    res.cnt = held;
  endtask

  // Drive one request from a falling edge and hold it until taken
  task automatic send_request(input logic [CMD_W-1:0] op, input logic [ITEM_PORT_W-1:0] data,
                              input logic [POS_W-1:0] pos, input bit typed,
                              input deque_result_t typed_res);
    deque_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      start_i    <= 1'b0;
      cmd_i      <= CMD_W'($urandom);
      item_in_i  <= {$urandom, $urandom};
      position_i <= POS_W'($urandom);
      @(negedge clk_i);
    end
    start_i    <= 1'b1;
    cmd_i      <= op;
    item_in_i  <= data;
    position_i <= pos;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_request(op, data, pos, res);
    if (typed) due_results.push_back(typed_res);
    else due_results.push_back(res);
    @(negedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = due_results.pop_front();
        if (item_out_o !== want.item)
          report_mismatch($sformatf("item_out %h, expected %h", item_out_o, want.item));
        if (status_o !== want.st)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.st));
        if (count_o !== want.cnt)
          report_mismatch($sformatf("count %0d, expected %0d", count_o, want.cnt));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    deque_result_t    none;
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    int               run_left;
    int               push_bias;
    int               pick;
    none = '{'0, ST_OK, '0};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_table[i].op, dir_table[i].data, dir_table[i].pos,
                   dir_table[i].typed, dir_table[i].res);

    // Random phases: no gaps, heavy gaps, no gaps, moderate gaps
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 49 : (ph == 3) ? 38 : 0;
      run_left = 0;
      push_bias = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // runs that fill toward full, drain toward empty, or mix
        if (run_left == 0) begin
          run_left = $urandom_range(200, 20);
          pick = $urandom_range(2);
          push_bias = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
        end
        run_left--;
        pick = $urandom_range(99);
        if (pick < 3) begin
          op = CMD_CMD_SPARE();
        end else if (pick < 28) begin
          op = CMD_READ;
        end else if ($urandom_range(99) < push_bias) begin
          op = $urandom_range(1) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
        end else begin
          op = $urandom_range(1) ? CMD_POP_HEAD : CMD_POP_TAIL;
        end
        if (held != 0 && $urandom_range(99) < 85) pos = POS_W'($urandom_range(held - 1));
        else pos = POS_W'($urandom);
        send_request(op, {$urandom, $urandom}, pos, 1'b0, none);
      end
    end
    start_i <= 1'b0;

    for (int w = 0; w < 1000 && due_results.size() != 0; w++) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    if (mismatch_cnt == 0) begin
      $display("ring_buffer_deque: match");
    end else begin
      $display("ring_buffer_deque: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("ring_buffer_deque: mismatch");
    $finish;
  end

endmodule

/* ring_buffer_deque.f */
sv/rbd_pkg.sv
sv/rbd_datapath.sv
sv/rbd_ctrl.sv
sv/ring_buffer_deque.sv
sv/rbd_checker.sv
verif/testbench.sv
